// ===== src/ccrfp_pkg.sv =====
// Shared types, constants and the CRC-32 byte step of the record frame parser.
`timescale 1ns / 1ps

package ccrfp_pkg;

  // Configuration register indexes
  localparam logic CFG_W = 1'b1;
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  // Register reset values
  localparam logic [31:0] MAGIC_RESET   = 32'h4441_5441;
  localparam logic [15:0] VERSION_RESET = 16'h0001;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_TRUNCATED   = 3'd3;
  localparam logic [2:0] ST_MISMATCH    = 3'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Output queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] byte_val;
    logic [2:0] status;
    logic       last;
  } res_t;

  // Push controls from the parser into the output queue
  typedef struct packed {
    logic push0;
    logic push1;
  } push_ctl_t;

  // One byte through the reflected CRC-32, bit at a time
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/ccrfp_out_fifo.sv =====
// Small flop-based result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps

module ccrfp_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  ccrfp_pkg::push_ctl_t push_ctl,
  input  ccrfp_pkg::res_t     push_d0,
  input  ccrfp_pkg::res_t     push_d1,
  output logic                room_two,
  output logic                out_valid,
  input  logic                out_stall,
  output ccrfp_pkg::res_t     out_d
);

  localparam int DEPTH = ccrfp_pkg::FIFO_DEPTH;
  localparam int PW    = ccrfp_pkg::FIFO_PTR_W;
  localparam int CW    = ccrfp_pkg::FIFO_CNT_W;

  ccrfp_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   tail_p1;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_d     = mem_r[head_r];
  assign pop       = out_valid && !out_stall;
  // Accept a new item only if two free slots remain
  assign room_two  = (count_r <= CW'(DEPTH - 2));
  assign tail_p1   = tail_r + PW'(1);

  // Pointer and count update
  always_comb begin
    head_nxt  = pop ? head_r + PW'(1) : head_r;
    tail_nxt  = tail_r + PW'(push_ctl.push0) + PW'(push_ctl.push1);
    count_nxt = count_r + CW'(push_ctl.push0) + CW'(push_ctl.push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage; second push lands after the first
  always_ff @(posedge clk) begin
    if (push_ctl.push0) begin
      mem_r[tail_r] <= push_d0;
    end
    if (push_ctl.push1) begin
      mem_r[tail_p1] <= push_d1;
    end
  end

endmodule

// ===== src/crc_checked_record_frame_parser.sv =====
// Top level of the CRC-checked record frame parser.
`timescale 1ns / 1ps

// Takes a file one byte per item on the in_ channel (in_end_of_file marks the
// last byte). The first 16 bytes are a little-endian header: magic, version,
// flags, payload length, stored CRC. Magic and version are checked against
// the cfg_ registers (index 0 magic, 1 version), then that many payload bytes
// are passed out as payload items and checked with reflected CRC-32.
// One status item closes each file; bytes after it are dropped up to EOF.
// Throughput: one byte per clock while in_stall is low. Each byte is parsed
// in the cycle it is accepted; its results go into a 4-entry output queue and
// show on out_ once they reach its head. A byte that ends the payload yields
// two items, which drain at one per cycle while out_stall is low. in_stall
// rises only when the queue has fewer than two free slots, so a stalled
// receiver backs up the input after at most three bytes that produce results.
// Reset (synchronous, rst_n low) empties the queue, returns to the header
// phase and reloads the cfg_ registers with their defaults.
module crc_checked_record_frame_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [ccrfp_pkg::CFG_W-1:0] cfg_index,
  input  logic [31:0]           cfg_wr_data,
  // input bytes
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_file,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [7:0]            out_payload_byte,
  output logic [2:0]            out_status_code,
  output logic                  out_last_result
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [3:0]      pos_r, pos_nxt;
  logic [31:0]     magic_r, magic_nxt;
  logic [15:0]     version_r, version_nxt;
  logic [31:0]     length_r, length_nxt;
  logic [31:0]     stored_r, stored_nxt;
  logic [31:0]     remain_r, remain_nxt;
  logic [31:0]     crc_r, crc_nxt;
  logic [31:0]     exp_magic_r;
  logic [15:0]     exp_version_r;

  logic                  accept;
  logic                  room_two;
  logic                  have_status;
  logic [2:0]            status;
  logic [31:0]           crc_step;
  ccrfp_pkg::push_ctl_t  push_ctl;
  ccrfp_pkg::res_t       res0, res1, head_res;

  assign in_stall = !room_two;
  assign accept   = in_valid && room_two;
  assign crc_step = ccrfp_pkg::crc32_byte(crc_r, in_data_byte);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_magic_r   <= ccrfp_pkg::MAGIC_RESET;
      exp_version_r <= ccrfp_pkg::VERSION_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ccrfp_pkg::REG_MAGIC:   exp_magic_r   <= cfg_wr_data;
        ccrfp_pkg::REG_VERSION: exp_version_r <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Parse one byte per accepted item
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    magic_nxt   = magic_r;
    version_nxt = version_r;
    length_nxt  = length_r;
    stored_nxt  = stored_r;
    remain_nxt  = remain_r;
    crc_nxt     = crc_r;
    have_status = 1'b0;
    status      = ccrfp_pkg::ST_OK;
    push_ctl    = '0;
    res0        = '0;
    res1        = '0;

    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          // Drop the byte into its header field
          case (pos_r[3:2])
            2'd0: magic_nxt[pos_r[1:0]*8 +: 8] = in_data_byte;
            2'd1: begin
              if (!pos_r[1]) begin
                version_nxt[pos_r[0]*8 +: 8] = in_data_byte;
              end
            end
            2'd2: length_nxt[pos_r[1:0]*8 +: 8] = in_data_byte;
            default: stored_nxt[pos_r[1:0]*8 +: 8] = in_data_byte;
          endcase
          if (pos_r == 4'd15) begin
            // Header complete: magic first, then version, then empty payload
            pos_nxt = '0;
            if (magic_r != exp_magic_r) begin
              have_status = 1'b1;
              status      = ccrfp_pkg::ST_BAD_MAGIC;
            end else if (version_r != exp_version_r) begin
              have_status = 1'b1;
              status      = ccrfp_pkg::ST_BAD_VERSION;
            end else if (length_r == '0) begin
              have_status = 1'b1;
              status      = (stored_nxt == '0) ? ccrfp_pkg::ST_OK : ccrfp_pkg::ST_MISMATCH;
            end else begin
              remain_nxt = length_r;
              crc_nxt    = ccrfp_pkg::CRC_ONES;
              phase_nxt  = PH_PAYLOAD;
              if (in_end_of_file) begin
                have_status = 1'b1;
                status      = ccrfp_pkg::ST_TRUNCATED;
              end
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
            if (in_end_of_file) begin
              have_status = 1'b1;
              status      = ccrfp_pkg::ST_TRUNCATED;
            end
          end
          // Status is the only result of a header byte
          push_ctl.push0 = have_status;
          res0.kind      = ccrfp_pkg::KIND_STATUS;
          res0.status    = status;
          res0.last      = in_end_of_file;
        end
        PH_PAYLOAD: begin
          // Pass the byte through, fold it into the CRC
          push_ctl.push0 = 1'b1;
          res0.kind      = ccrfp_pkg::KIND_PAYLOAD;
          res0.byte_val  = in_data_byte;
          crc_nxt        = crc_step;
          remain_nxt     = remain_r - 32'd1;
          if (remain_r == 32'd1) begin
            have_status = 1'b1;
            status      = ((crc_step ^ ccrfp_pkg::CRC_ONES) == stored_r) ?
                          ccrfp_pkg::ST_OK : ccrfp_pkg::ST_MISMATCH;
          end else if (in_end_of_file) begin
            have_status = 1'b1;
            status      = ccrfp_pkg::ST_TRUNCATED;
          end
          push_ctl.push1 = have_status;
          res1.kind      = ccrfp_pkg::KIND_STATUS;
          res1.status    = status;
          res1.last      = in_end_of_file;
        end
        default: ;  // done: drop bytes until end of file
      endcase

      if (have_status) begin
        phase_nxt = PH_DONE;
      end
      // End of file readies the next file
      if (in_end_of_file) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Header fields and payload tracking
  always_ff @(posedge clk) begin
    magic_r   <= magic_nxt;
    version_r <= version_nxt;
    length_r  <= length_nxt;
    stored_r  <= stored_nxt;
    remain_r  <= remain_nxt;
    crc_r     <= crc_nxt;
  end

  // Result queue
  ccrfp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_ctl  (push_ctl),
    .push_d0   (res0),
    .push_d1   (res1),
    .room_two  (room_two),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_d     (head_res)
  );

  assign out_result_kind  = head_res.kind;
  assign out_payload_byte = head_res.byte_val;
  assign out_status_code  = head_res.status;
  assign out_last_result  = head_res.last;

endmodule
